// ----- rtl/drm_pkg.sv -----
package drm_pkg;

   localparam int unsigned DIV_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 20;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NO_DROP_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DROP_FACTOR = 2'd2;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd100;
   localparam logic [19:0] NO_DROP_LIMIT_RESET = 20'd20000;
   localparam logic [6:0] DROP_FACTOR_RESET = 7'd20;

   localparam logic [DIV_WIDTH-1:0] RATE_NUMER = 16'd60000;
   localparam logic [DIV_WIDTH-1:0] VOL_UNIT = 16'd100;
   localparam logic [31:0] FIRST_DROP_TIME = 32'hFFFF_D8F1;
   localparam logic [31:0] GAP_STOPPED = 32'hFFFF_FFFF;

   typedef struct packed {
      logic step;
      logic div_run;
      logic vol_add;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// ----- rtl/drm_ctrl.sv -----
module drm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  drm_pkg::status_type  status,
   output drm_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VOL_DIV,
      ST_VOL_ADD,
      ST_RATE_DIV,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.step = 1'b1;
               state_in = ST_VOL_DIV;
            end
         end
         ST_VOL_DIV: begin
            cmd.div_run = 1'b1;
            if (status.div_last) begin
               state_in = ST_VOL_ADD;
            end
         end
         ST_VOL_ADD: begin
            cmd.vol_add = 1'b1;
            state_in    = ST_RATE_DIV;
         end
         ST_RATE_DIV: begin
            cmd.div_run = 1'b1;
            if (status.div_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- rtl/drm_datapath.sv -----
module drm_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_sensor_level,
   input  logic                                  csr_wen,
   input  logic [drm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [drm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   input  drm_pkg::cmd_type                      cmd,
   output drm_pkg::status_type                   status,
   output logic                                  rsp_drop_seen,
   output logic [31:0]                           rsp_drop_total,
   output logic [15:0]                           rsp_drops_per_minute,
   output logic [31:0]                           rsp_volume_hundredths_ml,
   output logic [31:0]                           rsp_gap_ms,
   output logic                                  rsp_flowing
);

   localparam int unsigned CntWidth = $clog2(drm_pkg::DIV_WIDTH);

   logic [15:0] debounce_ff;
   logic [19:0] limit_ff;
   logic [6:0]  factor_ff;

   logic        prev_ff;
   logic [31:0] now_ff;
   logic [31:0] accept_time_ff, accept_time_in;
   logic [31:0] drop_time_ff, drop_time_in;
   logic        first_ff, first_in;
   logic [31:0] interval_ff, interval_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] volume_ff;
   logic [20:0] low_run_ff, low_run_in;
   logic        seen_ff, seen_in;

   logic [drm_pkg::DIV_WIDTH:0]   rem_ff, rem_in;
   logic [drm_pkg::DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [drm_pkg::DIV_WIDTH-1:0] dvs_ff;
   logic [CntWidth-1:0]           cnt_ff;
   logic [drm_pkg::DIV_WIDTH:0]   shifted;
   logic                          ge;

   logic [31:0] elapsed;
   logic [31:0] dtime_eff;
   logic [15:0] rate;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= drm_pkg::DEBOUNCE_RESET;
         limit_ff    <= drm_pkg::NO_DROP_LIMIT_RESET;
         factor_ff   <= drm_pkg::DROP_FACTOR_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            drm_pkg::CSR_DEBOUNCE:      debounce_ff <= csr_wdata[15:0];
            drm_pkg::CSR_NO_DROP_LIMIT: limit_ff    <= csr_wdata[19:0];
            drm_pkg::CSR_DROP_FACTOR:   factor_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // drop logic, then timer logic
   assign elapsed   = now_ff - accept_time_ff;
   assign dtime_eff = first_ff ? drop_time_ff : drm_pkg::FIRST_DROP_TIME;

   always_comb begin
      seen_in        = (req_sensor_level != prev_ff) && req_sensor_level
                       && (elapsed >= {16'd0, debounce_ff});
      accept_time_in = accept_time_ff;
      drop_time_in   = drop_time_ff;
      first_in       = first_ff;
      interval_in    = interval_ff;
      count_in       = count_ff;
      low_run_in     = low_run_ff;
      if (seen_in) begin
         accept_time_in = now_ff;
         drop_time_in   = now_ff;
         first_in       = 1'b1;
         interval_in    = now_ff - dtime_eff;
         count_in       = count_ff + 32'd1;
      end
      if (!req_sensor_level) begin
         if (low_run_ff != '1) begin
            low_run_in = low_run_ff + 21'd1;
         end
         if (low_run_in >= {1'b0, limit_ff}) begin
            first_in    = 1'b0;
            interval_in = drm_pkg::GAP_STOPPED;
         end
      end else begin
         low_run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff        <= 1'b0;
         now_ff         <= '0;
         accept_time_ff <= '0;
         drop_time_ff   <= '0;
         first_ff       <= 1'b0;
         interval_ff    <= drm_pkg::GAP_STOPPED;
         count_ff       <= '0;
         volume_ff      <= '0;
         low_run_ff     <= '0;
         seen_ff        <= 1'b0;
      end else begin
         if (cmd.step) begin
            prev_ff        <= req_sensor_level;
            now_ff         <= now_ff + 32'd1;
            accept_time_ff <= accept_time_in;
            drop_time_ff   <= drop_time_in;
            first_ff       <= first_in;
            interval_ff    <= interval_in;
            count_ff       <= count_in;
            low_run_ff     <= low_run_in;
            seen_ff        <= seen_in;
         end
         if (cmd.vol_add && seen_ff && (factor_ff != '0)) begin
            volume_ff <= volume_ff + {16'd0, quo_ff};
         end
      end
   end

   // shared restoring divider, one quotient bit per cycle
   assign shifted = {rem_ff[drm_pkg::DIV_WIDTH-1:0], quo_ff[drm_pkg::DIV_WIDTH-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign rem_in  = ge ? shifted - {1'b0, dvs_ff} : shifted;
   assign quo_in  = {quo_ff[drm_pkg::DIV_WIDTH-2:0], ge};

   assign status.div_last = (cnt_ff == '1);

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rem_ff <= '0;
         quo_ff <= drm_pkg::VOL_UNIT;
         dvs_ff <= {9'd0, factor_ff};
         cnt_ff <= '0;
      end else if (cmd.vol_add) begin
         rem_ff <= '0;
         quo_ff <= drm_pkg::RATE_NUMER;
         dvs_ff <= interval_ff[15:0];
         cnt_ff <= '0;
      end else if (cmd.div_run) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + CntWidth'(1);
      end
   end

   always_comb begin
      unique if (interval_ff == '0) begin
         rate = drm_pkg::RATE_NUMER;
      end else if (interval_ff[31:16] != '0) begin
         rate = '0;
      end else begin
         rate = quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_drop_seen            <= seen_ff;
         rsp_drop_total           <= count_ff;
         rsp_drops_per_minute     <= rate;
         rsp_volume_hundredths_ml <= volume_ff;
         rsp_gap_ms               <= interval_ff;
         rsp_flowing              <= first_ff;
      end
   end

endmodule

// ----- rtl/drip_rate_monitor_core.sv -----
// An accepted request passes the volume divide, the volume add, the rate divide
// and the response load; the load waits while a previous response is still held.
// A new request is taken only once the previous one is loaded, after two 16-step
// passes of the shared radix-2 divider (volume increment, then drops per minute).
// Reset: synchronous, active high; clears all tick state, loads register defaults.
module drip_rate_monitor_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_sensor_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_drop_seen,
   output logic [31:0]                         rsp_drop_total,
   output logic [15:0]                         rsp_drops_per_minute,
   output logic [31:0]                         rsp_volume_hundredths_ml,
   output logic [31:0]                         rsp_gap_ms,
   output logic                                rsp_flowing,
   input  logic                                csr_wen,
   input  logic [drm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [drm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   drm_pkg::cmd_type    cmd;
   drm_pkg::status_type status;

   drm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   drm_datapath u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .req_sensor_level         (req_sensor_level),
      .csr_wen                  (csr_wen),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .cmd                      (cmd),
      .status                   (status),
      .rsp_drop_seen            (rsp_drop_seen),
      .rsp_drop_total           (rsp_drop_total),
      .rsp_drops_per_minute     (rsp_drops_per_minute),
      .rsp_volume_hundredths_ml (rsp_volume_hundredths_ml),
      .rsp_gap_ms               (rsp_gap_ms),
      .rsp_flowing              (rsp_flowing)
   );

endmodule

// ----- rtl/drm_checker.sv -----
module drm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_drop_seen,
   input logic [31:0]                         rsp_drop_total,
   input logic [15:0]                         rsp_drops_per_minute,
   input logic [31:0]                         rsp_volume_hundredths_ml,
   input logic [31:0]                         rsp_gap_ms,
   input logic                                rsp_flowing
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drop_total)
         && $stable(rsp_gap_ms) && $stable(rsp_volume_hundredths_ml))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_drop_flowing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drop_seen |-> rsp_flowing)
      else $error("drop reported without flow");

   a_stopped_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_flowing |-> (rsp_gap_ms == drm_pkg::GAP_STOPPED)
         && (rsp_drops_per_minute == '0))
      else $error("stopped flow with live gap or rate");

endmodule

bind drip_rate_monitor_core drm_checker u_drm_checker (.*);

// ----- sim/tb_top.sv -----
module tb_top;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam logic [31:0] FIRST_GAP_ORIGIN = 32'd0 - 32'd9999;
   localparam logic [31:0] DPM_NUMERATOR = 32'd60000;

   typedef struct packed {
      logic        drop_seen;
      logic [31:0] drop_total;
      logic [15:0] drops_per_minute;
      logic [31:0] volume_hundredths_ml;
      logic [31:0] gap_ms;
      logic        flowing;
   } drip_reading_type;

   class drip_tracker;
      logic [15:0] debounce_ms;
      logic [19:0] stop_limit_ms;
      logic [6:0]  drops_per_ml;
      logic        last_level;
      logic [31:0] tick_ms;
      logic [31:0] accepted_at;
      logic [31:0] last_drop_at;
      logic        running;
      logic [31:0] gap;
      logic [31:0] drops;
      logic [31:0] volume;
      logic [20:0] low_ticks;
      logic [15:0] dpm;
      int unsigned n_requests;
      int unsigned errors;
      drip_reading_type expected_readings[$];

      function new();
         debounce_ms = drm_pkg::DEBOUNCE_RESET;
         stop_limit_ms = drm_pkg::NO_DROP_LIMIT_RESET;
         drops_per_ml = drm_pkg::DROP_FACTOR_RESET;
         last_level = 1'b0;
         tick_ms = '0;
         accepted_at = '0;
         last_drop_at = '0;
         running = 1'b0;
         gap = '1;
         drops = '0;
         volume = '0;
         low_ticks = '0;
         dpm = '0;
         n_requests = 0;
         errors = 0;
      endfunction

      function void record_tick(logic level);
         drip_reading_type r;
         r.drop_seen = 1'b0;
         if (level != last_level) begin
            last_level = level;
            if (level && (tick_ms - accepted_at) >= {16'd0, debounce_ms}) begin
               r.drop_seen = 1'b1;
               accepted_at = tick_ms;
               if (!running) begin
                  running = 1'b1;
                  last_drop_at = FIRST_GAP_ORIGIN;
               end
               gap = tick_ms - last_drop_at;
               last_drop_at = tick_ms;
               drops = drops + 32'd1;
               if (drops_per_ml != 7'd0)
                  volume = volume + 32'd100 / {25'd0, drops_per_ml};
            end
         end
         if (!level) begin
            if (low_ticks != '1)
               low_ticks = low_ticks + 21'd1;
            if ({11'd0, low_ticks} >= {12'd0, stop_limit_ms}) begin
               running = 1'b0;
               gap = '1;
            end
         end else begin
            low_ticks = '0;
         end
         dpm = (gap == 32'd0) ? DPM_NUMERATOR[15:0] : 16'(DPM_NUMERATOR / gap);
         tick_ms = tick_ms + 32'd1;
         r.drop_total = drops;
         r.drops_per_minute = dpm;
         r.volume_hundredths_ml = volume;
         r.gap_ms = gap;
         r.flowing = running;
         expected_readings.push_back(r);
         n_requests++;
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_reading(drip_reading_type got);
         drip_reading_type want;
         if (expected_readings.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none, got drop_total %0d",
                     $time, got.drop_total);
         end else begin
            want = expected_readings.pop_front();
            compare_field("drop_seen", 32'(want.drop_seen), 32'(got.drop_seen));
            compare_field("drop_total", want.drop_total, got.drop_total);
            compare_field("drops_per_minute", 32'(want.drops_per_minute),
                          32'(got.drops_per_minute));
            compare_field("volume_hundredths_ml", want.volume_hundredths_ml,
                          got.volume_hundredths_ml);
            compare_field("gap_ms", want.gap_ms, got.gap_ms);
            compare_field("flowing", 32'(want.flowing), 32'(got.flowing));
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_sensor_level = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_drop_seen;
   logic [31:0]                         rsp_drop_total;
   logic [15:0]                         rsp_drops_per_minute;
   logic [31:0]                         rsp_volume_hundredths_ml;
   logic [31:0]                         rsp_gap_ms;
   logic                                rsp_flowing;
   logic                                csr_wen = 1'b0;
   logic [drm_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [drm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   drip_tracker sb = new();
   bit tick_levels[$];
   int unsigned cycle_count = 0;

   drip_rate_monitor_core u_top (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_sensor_level         (req_sensor_level),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_drop_seen            (rsp_drop_seen),
      .rsp_drop_total           (rsp_drop_total),
      .rsp_drops_per_minute     (rsp_drops_per_minute),
      .rsp_volume_hundredths_ml (rsp_volume_hundredths_ml),
      .rsp_gap_ms               (rsp_gap_ms),
      .rsp_flowing              (rsp_flowing),
      .csr_wen                  (csr_wen),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.record_tick(req_sensor_level);
         if (rsp_valid && rsp_ready)
            sb.check_reading({rsp_drop_seen, rsp_drop_total, rsp_drops_per_minute,
                              rsp_volume_hundredths_ml, rsp_gap_ms, rsp_flowing});
      end
   end

   initial begin : rsp_pacer
      int unsigned stretch;
      int unsigned style;
      bit held;
      held = 1'b0;
      forever begin
         if (!held && sb.n_requests >= 400) begin
            // hold off long enough for the request side to back up
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (800) @(posedge clock);
         end else begin
            stretch = $urandom_range(5, 150);
            style = $urandom_range(0, 3);
            repeat (stretch) begin
               case (style)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_ready <= 1'($urandom_range(0, 1));
                  default: rsp_ready <= ($urandom_range(0, 5) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   task automatic write_settings(input logic [15:0] dbc, input logic [19:0] lim,
                                 input logic [6:0] fac);
      csr_wen <= 1'b1;
      csr_index <= drm_pkg::CSR_DEBOUNCE;
      csr_wdata <= {4'd0, dbc};
      @(posedge clock);
      csr_index <= drm_pkg::CSR_NO_DROP_LIMIT;
      csr_wdata <= lim;
      @(posedge clock);
      csr_index <= drm_pkg::CSR_DROP_FACTOR;
      csr_wdata <= {13'd0, fac};
      @(posedge clock);
      csr_wen <= 1'b0;
      sb.debounce_ms = dbc;
      sb.stop_limit_ms = lim;
      sb.drops_per_ml = fac;
   endtask

   task automatic push_bits(input logic [31:0] bits, input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         tick_levels.push_back(bits[i]);
   endtask

   task automatic queue_flow(input int unsigned n_items);
      int unsigned hi;
      int unsigned lo;
      int unsigned cap;
      int unsigned spacing;
      int unsigned k;
      cap = (32'(sb.stop_limit_ms) < 200) ? 32'(sb.stop_limit_ms) + 6 : 200;
      spacing = (32'(sb.debounce_ms) < 30) ? 32'(sb.debounce_ms) + 3 : 30;
      k = 0;
      while (k < n_items) begin
         if ($urandom_range(0, 3) != 0) begin
            hi = $urandom_range(1, 4);
            lo = ($urandom_range(0, 4) == 0) ? $urandom_range(1, cap)
                                             : $urandom_range(1, spacing);
            repeat (hi) tick_levels.push_back(1'b1);
            repeat (lo) tick_levels.push_back(1'b0);
            k += hi + lo;
         end else begin
            repeat ($urandom_range(1, 8)) begin
               tick_levels.push_back(1'($urandom_range(0, 1)));
               k++;
            end
         end
      end
   endtask

   task automatic drive_ticks();
      int unsigned burst;
      burst = $urandom_range(1, 40);
      while (tick_levels.size() != 0) begin
         req_valid <= 1'b1;
         req_sensor_level <= tick_levels.pop_front();
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         burst--;
         if (burst == 0 && tick_levels.size() != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clock);
            burst = $urandom_range(1, 40);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (sb.expected_readings.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [15:0] dbc;
      logic [19:0] lim;
      logic [6:0]  fac;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_bits(32'b01, 2);
      queue_flow(110);
      drive_ticks();
      wait_idle();

      write_settings(16'd0, 20'd0, 7'd0);
      push_bits(32'b01001101, 8);
      drive_ticks();
      wait_idle();

      write_settings(16'hFFFF, 20'hFFFFF, 7'h7F);
      push_bits(32'b0101, 4);
      drive_ticks();
      wait_idle();

      write_settings(16'd1, 20'hFFFFF, 7'd101);
      push_bits(32'b101, 3);
      drive_ticks();
      wait_idle();

      write_settings(16'd2, 20'd1, 7'd100);
      push_bits(32'b0101, 4);
      drive_ticks();
      wait_idle();

      write_settings(16'd0, 20'd2, 7'd1);
      push_bits(32'b10011, 5);
      drive_ticks();
      wait_idle();

      for (int ph = 0; ph < 7; ph++) begin
         case ($urandom_range(0, 9))
            0: dbc = 16'd0;
            1: dbc = 16'($urandom_range(0, 16'hFFFF));
            default: dbc = 16'($urandom_range(1, 25));
         endcase
         case ($urandom_range(0, 9))
            0: lim = 20'd0;
            1: lim = 20'hFFFFF;
            2: lim = 20'($urandom_range(0, 20'hFFFFF));
            default: lim = 20'($urandom_range(1, 60));
         endcase
         case ($urandom_range(0, 9))
            0: fac = 7'd0;
            1: fac = 7'($urandom_range(101, 127));
            default: fac = 7'($urandom_range(1, 100));
         endcase
         write_settings(dbc, lim, fac);
         queue_flow(100);
         drive_ticks();
         wait_idle();
      end

      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.expected_readings.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
